/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DBM_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("degree_bucket_move: assertion failed");

// Next-cycle implication.
`define DBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("degree_bucket_move: assertion failed");

`endif

/* hw/rtl/dbm_pkg.sv */
// ----------------------------------------------------------------------------
// dbm_pkg
// Sizes, control word and status types shared by the bucket move block.
// ----------------------------------------------------------------------------
package dbm_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int MAX_BUCKET = 64;
    localparam int BUCKETS    = MAX_BUCKET + 1;

    // Port field widths.
    localparam int IDX_W     = 10;
    localparam int BKT_OUT_W = 7;
    localparam int POS_OUT_W = 10;
    localparam int SUM_W     = 17;

    // Internal widths.
    localparam int NODE_W    = $clog2(NODE_COUNT);
    localparam int BUCKET_W  = $clog2(BUCKETS);
    localparam int COUNT_W   = $clog2(NODE_COUNT + 1);
    localparam int MEM_DEPTH = BUCKETS * NODE_COUNT;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int CLEAR_LEN = (NODE_COUNT > BUCKETS) ? NODE_COUNT : BUCKETS;
    localparam int CLEAR_W   = $clog2(CLEAR_LEN);

    typedef struct packed {
        logic clear;
        logic accept;
        logic cnt_rd;
        logic mem_rd;
        logic remove;
        logic append;
        logic emit_refused;
    } ctrl_t;

    typedef struct packed {
        logic clear_last;
        logic in_take;
        logic refuse;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [NODE_W-1:0]   position;
        logic                refused;
    } result_t;

endpackage

/* hw/rtl/dbm_seq.sv */
// ----------------------------------------------------------------------------
// dbm_seq
// Step counter and control store; conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module dbm_seq
(
    input  logic            clk,
    input  logic            rst_n,
    input  dbm_pkg::stat_t  status,
    output dbm_pkg::ctrl_t  ctrl
);

    typedef enum logic [2:0]
    {
        COND_NEVER,
        COND_ALWAYS,
        COND_CLEAR_LAST,
        COND_IN_TAKE,
        COND_REFUSE,
        COND_OUT_FREE
    } cond_t;

    typedef logic [2:0] step_t;

    localparam step_t STEP_CLEAR  = 3'd0;
    localparam step_t STEP_WAIT   = 3'd1;
    localparam step_t STEP_COUNT  = 3'd2;
    localparam step_t STEP_CHECK  = 3'd3;
    localparam step_t STEP_REMOVE = 3'd4;
    localparam step_t STEP_APPEND = 3'd5;
    localparam step_t STEP_REFUSE = 3'd6;

    typedef struct packed {
        dbm_pkg::ctrl_t ctrl;
        cond_t          cond;
        step_t          target;
        logic           hold;
    } uword_t;

    function automatic uword_t rom_word(input step_t step);
        uword_t w;
        begin
            w        = '0;
            w.cond   = COND_NEVER;
            w.target = STEP_WAIT;
            case (step)
                STEP_CLEAR:
                begin
                    w.ctrl.clear = 1'b1;
                    w.cond       = COND_CLEAR_LAST;
                    w.target     = STEP_WAIT;
                    w.hold       = 1'b1;
                end
                STEP_WAIT:
                begin
                    w.ctrl.accept = 1'b1;
                    w.cond        = COND_IN_TAKE;
                    w.target      = STEP_COUNT;
                    w.hold        = 1'b1;
                end
                STEP_COUNT:
                begin
                    w.ctrl.cnt_rd = 1'b1;
                end
                STEP_CHECK:
                begin
                    w.ctrl.mem_rd = 1'b1;
                    w.cond        = COND_REFUSE;
                    w.target      = STEP_REFUSE;
                end
                STEP_REMOVE:
                begin
                    w.ctrl.remove = 1'b1;
                end
                STEP_APPEND:
                begin
                    w.ctrl.append = 1'b1;
                    w.cond        = COND_OUT_FREE;
                    w.target      = STEP_WAIT;
                    w.hold        = 1'b1;
                end
                STEP_REFUSE:
                begin
                    w.ctrl.emit_refused = 1'b1;
                    w.cond              = COND_OUT_FREE;
                    w.target            = STEP_WAIT;
                    w.hold              = 1'b1;
                end
                default:
                begin
                    w.cond   = COND_ALWAYS;
                    w.target = STEP_WAIT;
                end
            endcase
            return w;
        end
    endfunction

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   jump;

    always_comb
    begin
        word = rom_word(step_reg);
        case (word.cond)
            COND_NEVER:      jump = 1'b0;
            COND_ALWAYS:     jump = 1'b1;
            COND_CLEAR_LAST: jump = status.clear_last;
            COND_IN_TAKE:    jump = status.in_take;
            COND_REFUSE:     jump = status.refuse;
            COND_OUT_FREE:   jump = status.out_free;
            default:         jump = 1'b0;
        endcase
        if (jump)
        begin
            step_next = word.target;
        end
        else if (word.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + 3'd1;
        end
    end

    assign ctrl = word.ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* hw/rtl/dbm_datapath.sv */
// ----------------------------------------------------------------------------
// dbm_datapath
// Member, count and node tables, read registers and the weighted sum.
// ----------------------------------------------------------------------------
module dbm_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dbm_pkg::ctrl_t                ctrl,
    input  logic                          in_valid,
    input  logic [dbm_pkg::IDX_W-1:0]     node_index,
    input  logic                          kind,
    input  logic                          out_free,
    output dbm_pkg::stat_t                status,
    output dbm_pkg::result_t              res,
    output logic                          res_load,
    output logic [dbm_pkg::SUM_W-1:0]     weight
);

    function automatic logic [dbm_pkg::MEM_AW-1:0] mem_addr
    (
        input logic [dbm_pkg::BUCKET_W-1:0] b,
        input logic [dbm_pkg::NODE_W-1:0]   s
    );
        begin
            return dbm_pkg::MEM_AW'(b) * dbm_pkg::MEM_AW'(dbm_pkg::NODE_COUNT)
                 + dbm_pkg::MEM_AW'(s);
        end
    endfunction

    logic [dbm_pkg::NODE_W-1:0]   members_mem [0:dbm_pkg::MEM_DEPTH-1];
    logic [dbm_pkg::COUNT_W-1:0]  cnt_mem     [0:dbm_pkg::BUCKETS-1];
    logic [dbm_pkg::BUCKET_W-1:0] bkt_mem     [0:dbm_pkg::NODE_COUNT-1];
    logic [dbm_pkg::NODE_W-1:0]   pos_mem     [0:dbm_pkg::NODE_COUNT-1];

    logic [dbm_pkg::NODE_W-1:0]   x_reg;
    logic                         kind_reg;
    logic                         range_reg;
    logic [dbm_pkg::BUCKET_W-1:0] b_reg;
    logic [dbm_pkg::NODE_W-1:0]   p_reg;
    logic [dbm_pkg::COUNT_W-1:0]  cnt_b_reg;
    logic [dbm_pkg::COUNT_W-1:0]  cnt_nb_reg;
    logic [dbm_pkg::NODE_W-1:0]   mover_reg;
    logic [dbm_pkg::CLEAR_W-1:0]  clr_reg;
    logic [dbm_pkg::CLEAR_W-1:0]  clr_next;
    logic [dbm_pkg::SUM_W-1:0]    weight_reg;
    logic [dbm_pkg::SUM_W-1:0]    weight_next;

    logic [dbm_pkg::BUCKET_W-1:0] nb;
    logic [dbm_pkg::NODE_W-1:0]   last;
    logic [dbm_pkg::NODE_W-1:0]   mover;
    logic [dbm_pkg::NODE_W-1:0]   slot;
    logic [dbm_pkg::NODE_W-1:0]   clr_node;
    logic                         clr_node_en;
    logic                         clr_cnt_en;
    logic                         refuse;
    logic                         in_take;
    logic                         do_append;

    logic                         mw_en;
    logic [dbm_pkg::MEM_AW-1:0]   mw_addr;
    logic [dbm_pkg::NODE_W-1:0]   mw_data;
    logic                         pw_en;
    logic [dbm_pkg::NODE_W-1:0]   pw_addr;
    logic [dbm_pkg::NODE_W-1:0]   pw_data;
    logic                         bw_en;
    logic [dbm_pkg::NODE_W-1:0]   bw_addr;
    logic [dbm_pkg::BUCKET_W-1:0] bw_data;
    logic                         cw_en;
    logic [dbm_pkg::BUCKET_W-1:0] cw_addr;
    logic [dbm_pkg::COUNT_W-1:0]  cw_data;

    always_comb
    begin
        in_take   = ctrl.accept & in_valid;
        do_append = ctrl.append & out_free;

        nb    = kind_reg ? (b_reg - 1'b1) : (b_reg + 1'b1);
        last  = dbm_pkg::NODE_W'(cnt_b_reg - 1'b1);
        mover = ({1'b0, mover_reg} >= dbm_pkg::COUNT_W'(dbm_pkg::NODE_COUNT))
              ? x_reg : mover_reg;
        slot  = (cnt_nb_reg >= dbm_pkg::COUNT_W'(dbm_pkg::NODE_COUNT))
              ? dbm_pkg::NODE_W'(dbm_pkg::NODE_COUNT - 1)
              : dbm_pkg::NODE_W'(cnt_nb_reg);

        refuse = !range_reg || (cnt_b_reg == '0)
              || (!kind_reg && (b_reg == dbm_pkg::BUCKET_W'(dbm_pkg::MAX_BUCKET)))
              || (kind_reg && (b_reg == '0));

        clr_node    = dbm_pkg::NODE_W'(clr_reg);
        clr_node_en = ctrl.clear && (32'(clr_reg) < dbm_pkg::NODE_COUNT);
        clr_cnt_en  = ctrl.clear && (32'(clr_reg) < dbm_pkg::BUCKETS);
        clr_next    = (ctrl.clear && !status.clear_last) ? (clr_reg + 1'b1) : clr_reg;

        // Member list port
        mw_en   = clr_node_en | ctrl.remove | do_append;
        mw_addr = mem_addr('0, clr_node);
        mw_data = clr_node;
        if (ctrl.remove)
        begin
            mw_addr = mem_addr(b_reg, p_reg);
            mw_data = mover;
        end
        else if (ctrl.append)
        begin
            mw_addr = mem_addr(nb, slot);
            mw_data = x_reg;
        end

        // Node position port
        pw_en   = clr_node_en | ctrl.remove | do_append;
        pw_addr = clr_node;
        pw_data = clr_node;
        if (ctrl.remove)
        begin
            pw_addr = mover;
            pw_data = p_reg;
        end
        else if (ctrl.append)
        begin
            pw_addr = x_reg;
            pw_data = slot;
        end

        // Node bucket port
        bw_en   = clr_node_en | do_append;
        bw_addr = ctrl.append ? x_reg : clr_node;
        bw_data = ctrl.append ? nb : '0;

        // Count port
        cw_en   = clr_cnt_en | ctrl.remove | do_append;
        cw_addr = dbm_pkg::BUCKET_W'(clr_reg);
        cw_data = (clr_reg == '0) ? dbm_pkg::COUNT_W'(dbm_pkg::NODE_COUNT) : '0;
        if (ctrl.remove)
        begin
            cw_addr = b_reg;
            cw_data = dbm_pkg::COUNT_W'(last);
        end
        else if (ctrl.append)
        begin
            cw_addr = nb;
            cw_data = dbm_pkg::COUNT_W'(slot) + 1'b1;
        end

        weight_next = weight_reg;
        if (do_append)
        begin
            weight_next = kind_reg ? (weight_reg - 1'b1) : (weight_reg + 1'b1);
        end

        res.refused  = ctrl.emit_refused;
        res.bucket   = nb;
        res.position = slot;
        if (ctrl.emit_refused)
        begin
            res.bucket   = range_reg ? b_reg : '0;
            res.position = range_reg ? p_reg : '0;
        end
        res_load = do_append | (ctrl.emit_refused & out_free);
    end

    assign weight            = weight_next;
    assign status.clear_last = (clr_reg == dbm_pkg::CLEAR_W'(dbm_pkg::CLEAR_LEN - 1));
    assign status.in_take    = in_take;
    assign status.refuse     = refuse;
    assign status.out_free   = out_free;

    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            members_mem[mw_addr] <= mw_data;
        end
        if (pw_en)
        begin
            pos_mem[pw_addr] <= pw_data;
        end
        if (bw_en)
        begin
            bkt_mem[bw_addr] <= bw_data;
        end
        if (cw_en)
        begin
            cnt_mem[cw_addr] <= cw_data;
        end
        if (in_take)
        begin
            x_reg     <= dbm_pkg::NODE_W'(node_index);
            kind_reg  <= kind;
            range_reg <= (32'(node_index) < dbm_pkg::NODE_COUNT);
            b_reg     <= bkt_mem[dbm_pkg::NODE_W'(node_index)];
            p_reg     <= pos_mem[dbm_pkg::NODE_W'(node_index)];
        end
        if (ctrl.cnt_rd)
        begin
            cnt_b_reg  <= cnt_mem[b_reg];
            cnt_nb_reg <= cnt_mem[nb];
        end
        if (ctrl.mem_rd)
        begin
            mover_reg <= members_mem[mem_addr(b_reg, last)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            weight_reg <= '0;
        end
        else
        begin
            clr_reg    <= clr_next;
            weight_reg <= weight_next;
        end
    end

endmodule

/* hw/rtl/degree_bucket_move.sv */
// ----------------------------------------------------------------------------
// degree_bucket_move
// Bucketed node set: swap-remove a node from its bucket, append it to the
// neighbor bucket, and report its new place and the weighted bucket sum.
// ----------------------------------------------------------------------------
// After reset a clearing pass loads bucket 0 with every node in index order
// and zeroes the other counts; in this time in_stall stays high. Items then
// go through one at a time: a move steps through the count lookup, member
// read, removal and append, which registers its result, and a refused move
// goes from the member read to a refusal step that registers it; both hold
// while the output register is full. The single port of the member table
// needs a read of the bucket's last member and two writes (vacated slot,
// append slot) after the node and count lookups. The result sits in an
// output register, so a new item is taken while it waits.
module degree_bucket_move
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dbm_pkg::IDX_W-1:0]       node_index,
    input  logic                            kind,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dbm_pkg::BKT_OUT_W-1:0]   new_bucket,
    output logic [dbm_pkg::POS_OUT_W-1:0]   new_position,
    output logic [dbm_pkg::SUM_W-1:0]       weighted_sum,
    output logic                            refused
);

    dbm_pkg::ctrl_t                 ctrl;
    dbm_pkg::stat_t                 status;
    dbm_pkg::result_t               res;
    logic                           res_load;
    logic [dbm_pkg::SUM_W-1:0]      weight;
    logic                           out_free;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [dbm_pkg::BKT_OUT_W-1:0]  bucket_reg;
    logic [dbm_pkg::POS_OUT_W-1:0]  position_reg;
    logic [dbm_pkg::SUM_W-1:0]      sum_reg;
    logic                           refused_reg;

    dbm_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    dbm_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_valid   (in_valid),
        .node_index (node_index),
        .kind       (kind),
        .out_free   (out_free),
        .status     (status),
        .res        (res),
        .res_load   (res_load),
        .weight     (weight)
    );

    assign in_stall = !ctrl.accept;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            bucket_reg   <= dbm_pkg::BKT_OUT_W'(res.bucket);
            position_reg <= dbm_pkg::POS_OUT_W'(res.position);
            sum_reg      <= weight;
            refused_reg  <= res.refused;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_bucket   = bucket_reg;
    assign new_position = position_reg;
    assign weighted_sum = sum_reg;
    assign refused      = refused_reg;

endmodule

/* hw/rtl/dbm_checker.sv */
// ----------------------------------------------------------------------------
// dbm_checker
// Port-level checks on the bucket move block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbm_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [dbm_pkg::SUM_W-1:0]       weighted_sum,
    input  logic                            refused
);

    logic [dbm_pkg::SUM_W-1:0] sum_prev_reg;
    logic                      sum_stepped;

    // Hold the sum of the last delivered item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_prev_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            sum_prev_reg <= weighted_sum;
        end
    end

    assign sum_stepped = (weighted_sum == sum_prev_reg + 1'b1)
                      || (weighted_sum == sum_prev_reg - 1'b1);

    `DBM_ASSERT(a_refused_sum, out_valid && refused, weighted_sum == sum_prev_reg)
    `DBM_ASSERT(a_move_sum, out_valid && !refused, sum_stepped)
    `DBM_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)
    `DBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind degree_bucket_move dbm_checker u_dbm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .weighted_sum (weighted_sum),
    .refused      (refused)
);
